// File: src/gsl_pkg.sv
// Package for the grouped symbol list: action and status codes, field widths
// and the control bundle that drives each storage cell.
// No dependencies.
package gsl_pkg;

   localparam int ACTION_W = 3;
   localparam int SYMBOL_W = 8;
   localparam int INDEX_W  = 5;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_GET    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic capture;
      logic live;
      logic load_sym;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

endpackage

// File: src/gsl_cell.sv
// One storage cell of the grouped symbol list: holds one entry and its match flag.
// Depends on gsl_pkg for the symbol width and the cell control bundle.
module gsl_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  gsl_pkg::cell_ctrl_type             ctrl,
   input  logic [gsl_pkg::SYMBOL_W-1:0]       symbol,
   input  logic [gsl_pkg::SYMBOL_W-1:0]       left_entry,
   input  logic [gsl_pkg::SYMBOL_W-1:0]       right_entry,
   output logic [gsl_pkg::SYMBOL_W-1:0]       entry,
   output logic                               match
);

   logic [gsl_pkg::SYMBOL_W-1:0] entry_ff;
   logic [gsl_pkg::SYMBOL_W-1:0] entry_in;
   logic                         match_ff;
   logic                         match_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load_sym) begin
         entry_in = symbol;
      end else if (ctrl.take_left) begin
         entry_in = left_entry;
      end else if (ctrl.take_right) begin
         entry_in = right_entry;
      end
      match_in = match_ff;
      if (ctrl.capture) begin
         match_in = ctrl.live && (entry_ff == symbol);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// File: src/grouped_symbol_list.sv
// Top level of the grouped symbol list: control, count and the row of cells.
// Depends on gsl_pkg and gsl_cell.
//
// The block keeps an ordered list of up to CAPACITY byte symbols, one per cell.
// Commands arrive on the req_ channel (action, symbol, index) and every command
// produces exactly one transfer on the rsp_ channel with found, position,
// symbol_out, the count after the command and a status code.
// A command is taken when req_valid and req_ready are high. In the next cycle
// every cell compares its entry with the symbol and stores a match flag. Then,
// in the update step and once the output register is free, the first match is
// picked from the flags, the cells shift or load in parallel, and the result
// enters the output register, which raises rsp_valid. A new command is taken
// once the previous one has been written to the output register, so the block
// never holds more than one command in its compare and update steps.
// When rsp_ready is low the held result stays on rsp_ and the block may still
// take one more command; it then waits in its update step until the output
// register is free.
// Reset empties the list and drops rsp_valid. Entries are not cleared; an entry
// is only ever reported or matched after it has been written.
module grouped_symbol_list #(
   parameter int CAPACITY = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gsl_pkg::ACTION_W-1:0]    req_action,
   input  logic [gsl_pkg::SYMBOL_W-1:0]    req_symbol,
   input  logic [gsl_pkg::INDEX_W-1:0]     req_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [gsl_pkg::POS_W-1:0]       rsp_position,
   output logic [gsl_pkg::SYMBOL_W-1:0]    rsp_symbol_out,
   output logic [gsl_pkg::COUNT_W-1:0]     rsp_count,
   output logic [gsl_pkg::STATUS_W-1:0]    rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [gsl_pkg::ACTION_W-1:0] op_action_ff, op_action_in;
   logic [gsl_pkg::SYMBOL_W-1:0] op_symbol_ff, op_symbol_in;
   logic [gsl_pkg::INDEX_W-1:0]  op_index_ff, op_index_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [gsl_pkg::POS_W-1:0]     rsp_position_ff, rsp_position_in;
   logic [gsl_pkg::SYMBOL_W-1:0]  rsp_symbol_out_ff, rsp_symbol_out_in;
   logic [gsl_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [gsl_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [gsl_pkg::SYMBOL_W-1:0] entry [CAPACITY];
   logic [gsl_pkg::SYMBOL_W-1:0] left_entry [CAPACITY];
   logic [gsl_pkg::SYMBOL_W-1:0] right_entry [CAPACITY];
   gsl_pkg::cell_ctrl_type       ctrl [CAPACITY];

   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] first;
   logic [CAPACITY-1:0] tail;
   logic [CAPACITY-1:0] sel;
   logic [CAPACITY-1:0] below;
   logic [CAPACITY-1:0] above;
   logic [CAPACITY-1:0] live;
   logic                any_match;
   logic                full;
   logic                get_ok;
   logic                commit;
   logic [gsl_pkg::POS_W-1:0]    first_pos;
   logic [gsl_pkg::SYMBOL_W-1:0] get_entry;

   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live[i] = (32'(i) < 32'(count_ff));
         left_entry[i]  = (i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1];
         right_entry[i] = (i == CAPACITY - 1) ? '0 : entry[(i == CAPACITY - 1) ? i : i + 1];
      end
   end

   always_comb begin
      any_match = |match;
      first     = match & (~match + CAPACITY'(1));
      tail      = CAPACITY'(1) << count_ff;
      full      = (count_ff >= CNT_W'(CAPACITY));
      get_ok    = (32'(op_index_ff) < 32'(count_ff));
      sel       = '0;
      unique case (op_action_ff)
         gsl_pkg::ACT_INSERT: sel = any_match ? first : tail;
         gsl_pkg::ACT_APPEND: sel = tail;
         gsl_pkg::ACT_REMOVE: sel = first;
         default:             sel = '0;
      endcase
      below = sel - CAPACITY'(1);
      above = ~(below | sel);
      first_pos = '0;
      get_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) begin
            first_pos = first_pos | gsl_pkg::POS_W'(i);
         end
         if (i == int'(op_index_ff)) begin
            get_entry = entry[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         ctrl[i].capture    = (state_ff == ST_MATCH);
         ctrl[i].live       = live[i];
         ctrl[i].load_sym   = 1'b0;
         ctrl[i].take_left  = 1'b0;
         ctrl[i].take_right = 1'b0;
         if (commit) begin
            unique case (op_action_ff)
               gsl_pkg::ACT_INSERT: begin
                  ctrl[i].load_sym  = !full && sel[i];
                  ctrl[i].take_left = !full && above[i];
               end
               gsl_pkg::ACT_APPEND: begin
                  ctrl[i].load_sym = !full && sel[i];
               end
               gsl_pkg::ACT_REMOVE: begin
                  ctrl[i].take_right = any_match && (above[i] || sel[i]);
               end
               default: begin
                  ctrl[i].load_sym = 1'b0;
               end
            endcase
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      gsl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl[g]),
         .symbol      (op_symbol_ff),
         .left_entry  (left_entry[g]),
         .right_entry (right_entry[g]),
         .entry       (entry[g]),
         .match       (match[g])
      );
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      op_action_in      = op_action_ff;
      op_symbol_in      = op_symbol_ff;
      op_index_in       = op_index_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_found_in      = rsp_found_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_symbol_out_in = rsp_symbol_out_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_action_in = req_action;
               op_symbol_in = req_symbol;
               op_index_in  = req_index;
               state_in     = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (commit) begin
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_found_in      = 1'b0;
               rsp_position_in   = '0;
               rsp_symbol_out_in = '0;
               rsp_status_in     = gsl_pkg::STS_OK;
               unique case (op_action_ff)
                  gsl_pkg::ACT_INSERT, gsl_pkg::ACT_APPEND: begin
                     if (full) begin
                        rsp_status_in = gsl_pkg::STS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  gsl_pkg::ACT_REMOVE: begin
                     if (any_match) begin
                        count_in        = count_ff - CNT_W'(1);
                        rsp_found_in    = 1'b1;
                        rsp_position_in = first_pos;
                     end else begin
                        rsp_status_in = gsl_pkg::STS_NOT_FOUND;
                     end
                  end
                  gsl_pkg::ACT_SEARCH: begin
                     if (any_match) begin
                        rsp_found_in    = 1'b1;
                        rsp_position_in = first_pos;
                     end else begin
                        rsp_status_in = gsl_pkg::STS_NOT_FOUND;
                     end
                  end
                  gsl_pkg::ACT_GET: begin
                     if (get_ok) begin
                        rsp_found_in      = 1'b1;
                        rsp_symbol_out_in = get_entry;
                     end else begin
                        rsp_status_in = gsl_pkg::STS_BAD_INDEX;
                     end
                  end
                  gsl_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     rsp_status_in = gsl_pkg::STS_OK;
                  end
               endcase
               rsp_count_in = gsl_pkg::COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_action_ff      <= op_action_in;
      op_symbol_ff      <= op_symbol_in;
      op_index_ff       <= op_index_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_symbol_out_ff <= rsp_symbol_out_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_symbol_out = rsp_symbol_out_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
